// ===== design/bae_pkg.sv =====
// Package for the bitmap allocator: sizes, request and status codes.
// Used by every module of the block; depends on nothing.
package bae_pkg;
  localparam int BITS_MAX   = 1024;
  localparam int WORD_BITS  = 32;
  localparam int WORD_COUNT = (BITS_MAX + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W     = $clog2(WORD_COUNT);
  localparam int BIDX_W     = $clog2(WORD_BITS);

  localparam logic [2:0] FN_GET    = 3'd0;
  localparam logic [2:0] FN_WRITE  = 3'd1;
  localparam logic [2:0] FN_FIRST  = 3'd2;
  localparam logic [2:0] FN_REGION = 3'd3;
  localparam logic [2:0] FN_COUNT  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_BAD       = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  position;
    logic        bit_value;
    logic [10:0] set_count;
  } result_t;
endpackage

// ===== design/bae_mem.sv =====
// Word memory holding the bitmap, one write and one registered read port.
// Depends on bae_pkg.
module bae_mem
  import bae_pkg::*;
(
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic [ADDR_W-1:0]    raddr,
  output logic [WORD_BITS-1:0] rdata
);
  logic [WORD_BITS-1:0] mem [WORD_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/bae_seq.sv =====
// Sequencer: walks the bitmap via a shared compare/count unit, one bit a cycle
// between word reads/write-backs of its buffer. Depends on bae_pkg, bae_mem.
module bae_seq
  import bae_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  func,
  input  logic [9:0]  offset,
  input  logic [10:0] run_length,
  input  logic        value,
  input  logic [10:0] size,
  output logic        busy,
  output logic        done,
  output result_t     res
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_BIT   = 3'd4;
  localparam logic [2:0] S_WB    = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]  state;
  logic [2:0]  fn;
  logic [10:0] p, last, len, run, cnt;
  logic        val;
  logic [WORD_BITS-1:0] buffer;
  logic        dirty;
  logic [ADDR_W-1:0] clr;

  logic                 we;
  logic [ADDR_W-1:0]    waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;

  bae_mem u_mem (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  wire [ADDR_W-1:0] paddr = p[BIDX_W+ADDR_W-1:BIDX_W];
  wire [BIDX_W-1:0] pbit  = p[BIDX_W-1:0];
  // p has already stepped past the last bit handled in the buffered word in S_WB
  wire [10:0]       pprev = p - 11'd1;
  wire              cur   = buffer[pbit];
  wire              hit   = (cur == val);
  wire [10:0]       run_n = run + 11'd1;
  wire              eow   = (pbit == BIDX_W'(WORD_BITS - 1));

  always_comb begin
    we    = 1'b0;
    waddr = pprev[BIDX_W+ADDR_W-1:BIDX_W];
    wdata = buffer;
    raddr = paddr;
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr;
      wdata = '0;
    end else if (state == S_WB) begin
      we = dirty;
    end
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == ADDR_W'(WORD_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            fn  <= func;
            val <= value;
            len <= run_length;
            run <= '0;
            cnt <= '0;
            dirty <= 1'b0;
            res <= '0;
            state <= S_RD;
            last <= size;
            if (func == FN_COUNT) begin
              p <= '0;
              if (size == 0) state <= S_DONE;
            end else begin
              p <= {1'b0, offset};
              if (func > FN_COUNT || {1'b0, offset} >= size ||
                  (func == FN_WRITE &&
                   ({2'b0, offset} + {1'b0, run_length}) > {1'b0, size}) ||
                  (func == FN_REGION && (run_length == 0 || run_length > size))) begin
                res.status <= ST_BAD;
                state <= S_DONE;
              end else if (func == FN_WRITE) begin
                last <= {1'b0, offset} + run_length;
                if (run_length == 0) state <= S_DONE;
              end else if (func == FN_FIRST || func == FN_REGION) begin
                res.status <= ST_NOT_FOUND;
              end
            end
          end
        end
        S_RD: state <= S_WAIT;
        S_WAIT: begin
          buffer <= rdata;
          state  <= S_BIT;
        end
        S_BIT: begin
          // one bit per cycle through the shared compare
          p <= p + 11'd1;
          unique case (fn)
            FN_GET: begin
              res.bit_value <= cur;
              state <= S_DONE;
            end
            FN_WRITE: begin
              buffer[pbit] <= val;
              dirty <= 1'b1;
            end
            FN_FIRST: begin
              if (hit) begin
                res.status <= ST_OK;
                res.position <= p[9:0];
                state <= S_DONE;
              end
            end
            FN_REGION: begin
              run <= hit ? run_n : '0;
              if (hit && run_n == len) begin
                res.status <= ST_OK;
                res.position <= 10'(p + 11'd1 - len);
                state <= S_DONE;
              end
            end
            default: cnt <= cnt + {10'd0, cur};
          endcase
          if (!(fn == FN_GET) &&
              !(fn == FN_FIRST && hit) &&
              !(fn == FN_REGION && hit && run_n == len)) begin
            if (p + 11'd1 >= last) state <= S_WB;
            else if (eow) state <= S_WB;
          end
        end
        S_WB: begin
          dirty <= 1'b0;
          if (p >= last) begin
            res.set_count <= (fn == FN_COUNT) ? cnt : '0;
            state <= S_DONE;
          end else begin
            state <= S_RD;
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/bitmap_allocator_engine.sv =====
// Top level of the first-fit bitmap allocator: stream ports, size register,
// output register. Depends on bae_pkg and bae_seq.
//
//  channel   direction  payload
//  s_axis    in         request: func, offset, run_length, value
//  m_axis    out        result: status, position, bit_value, set_count
//  cfg       in         bit_count
//
// For each word visited a request reads it, loads the word buffer, scans its
// bits one a cycle and writes the word back if changed; then it finishes.
// After reset a clearing pass zeros all 32 words of the memory; no request is
// taken meanwhile. The result holds in an output register until taken; a
// new request is taken once the sequencer is idle and that register is free.
module bitmap_allocator_engine
  import bae_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // func[2:0] offset[12:3] run_length[23:13] value[24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // status[1:0] position[11:2] bit_value[12] set_count[23:13]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);
  logic [10:0] bit_count;
  logic [10:0] size;
  logic        busy, done;
  result_t     res;

  assign cfg_ready = 1'b1;
  assign size = (bit_count > 11'(BITS_MAX)) ? 11'(BITS_MAX) : bit_count;
  // hold off while a finished result is on its way into the output register
  assign s_axis_tready = !busy && !done && !m_axis_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= 11'd1024;
    end else if (cfg_valid) begin
      bit_count <= cfg_data;
    end
  end

  bae_seq u_seq (
    .clk, .rst,
    .start      (s_axis_tvalid && s_axis_tready),
    .func       (s_axis_tdata[2:0]),
    .offset     (s_axis_tdata[12:3]),
    .run_length (s_axis_tdata[23:13]),
    .value      (s_axis_tdata[24]),
    .size, .busy, .done, .res
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {res.set_count, res.bit_value, res.position, res.status};
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end
endmodule

// ===== sim/bitmap_allocator_engine_test.sv =====
// Regression bench for bitmap_allocator_engine: directed and random requests
// checked against a bit-level shadow of the bitmap. Uses bae_pkg and the top.
`timescale 1ns / 1ps

module bitmap_allocator_engine_test;
  import bae_pkg::*;

  localparam logic [2:0] FN_RSVD_A = 3'd5;
  localparam logic [2:0] FN_RSVD_B = 3'd6;
  localparam logic [2:0] FN_RSVD_C = 3'd7;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int DRAIN_CYCLES = 1200;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;

  bitmap_allocator_engine u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  logic [BITS_MAX-1:0] shadow_bits;
  int                  shadow_size;
  result_t             pending_results[$];
  int                  error_count;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  hold_off_request;
  int                  hold_off_left;
  longint              cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow of the block: updates the bitmap and returns the expected result.
  function automatic result_t predict_bitmap_op(logic [2:0] fn, int off, int len, bit val);
    result_t r;
    int sz;
    int run;
    int cnt;
    r = '0;
    sz = shadow_size;
    run = 0;
    cnt = 0;
    case (fn)
      FN_GET: begin
        if (off >= sz) r.status = ST_BAD;
        else r.bit_value = shadow_bits[off];
      end
      FN_WRITE: begin
        if (off >= sz || off + len > sz) r.status = ST_BAD;
        else for (int p = off; p < off + len; p++) shadow_bits[p] = val;
      end
      FN_FIRST: begin
        if (off >= sz) r.status = ST_BAD;
        else begin
          r.status = ST_NOT_FOUND;
          for (int p = off; p < sz; p++) begin
            if (shadow_bits[p] == val) begin
              r.status = ST_OK;
              r.position = p[9:0];
              break;
            end
          end
        end
      end
      FN_REGION: begin
        if (off >= sz || len == 0 || len > sz) r.status = ST_BAD;
        else begin
          r.status = ST_NOT_FOUND;
          for (int p = off; p < sz; p++) begin
            if (shadow_bits[p] == val) begin
              run++;
              if (run == len) begin
                r.status = ST_OK;
                r.position = 10'(p + 1 - len);
                break;
              end
            end else begin
              run = 0;
            end
          end
        end
      end
      FN_COUNT: begin
        for (int p = 0; p < sz; p++) cnt += shadow_bits[p];
        r.set_count = cnt[10:0];
      end
      default: r.status = ST_BAD;
    endcase
    return r;
  endfunction

  task automatic send_request(logic [2:0] fn, int off, int len, bit val);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, val, len[10:0], off[9:0], fn};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_bitmap_op(fn, off[9:0], len[10:0], val));
  endtask

  // Change the size only with the block drained.
  task automatic write_bit_count(int value);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value[10:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_size = (value[10:0] < BITS_MAX) ? value[10:0] : BITS_MAX;
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_off_left = 0;
    end else begin
      if (hold_off_request > 0) begin
        hold_off_left = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status    = m_axis_tdata[1:0];
      got.position  = m_axis_tdata[11:2];
      got.bit_value = m_axis_tdata[12];
      got.set_count = m_axis_tdata[23:13];
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.position !== want.position ||
            got.bit_value !== want.bit_value || got.set_count !== want.set_count) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: exp st=%0d pos=%0d bit=%0d cnt=%0d, got st=%0d pos=%0d bit=%0d cnt=%0d",
                     want.status, want.position, want.bit_value, want.set_count,
                     got.status, got.position, got.bit_value, got.set_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bitmap_allocator_engine regression: fail");
      $finish;
    end
  end

  task automatic test_directed_full_size();
    send_request(FN_GET, 0, 0, 1'b0);
    send_request(FN_COUNT, 0, 0, 1'b0);
    send_request(FN_WRITE, 0, 1024, 1'b1);
    send_request(FN_COUNT, 0, 0, 1'b0);
    send_request(FN_FIRST, 0, 0, 1'b0);
    send_request(FN_REGION, 0, 1024, 1'b1);
    send_request(FN_WRITE, 3, 0, 1'b0);
    send_request(FN_WRITE, 1000, 100, 1'b0);
    send_request(FN_WRITE, 1014, 10, 1'b0);
    send_request(FN_GET, 1023, 0, 1'b0);
    send_request(FN_FIRST, 512, 0, 1'b0);
    send_request(FN_REGION, 0, 10, 1'b0);
    send_request(FN_REGION, 0, 11, 1'b0);
    send_request(FN_REGION, 5, 0, 1'b1);
    send_request(FN_REGION, 5, 1025, 1'b1);
    send_request(FN_REGION, 5, 2047, 1'b1);
    send_request(FN_RSVD_A, 0, 0, 1'b0);
    send_request(FN_RSVD_B, 1023, 2047, 1'b1);
    send_request(FN_RSVD_C, 7, 3, 1'b0);
    send_request(FN_COUNT, 0, 0, 1'b0);
  endtask

  task automatic test_size_extremes();
    write_bit_count(0);
    send_request(FN_GET, 0, 0, 1'b0);
    send_request(FN_WRITE, 0, 0, 1'b1);
    send_request(FN_FIRST, 0, 0, 1'b1);
    send_request(FN_REGION, 0, 1, 1'b1);
    send_request(FN_COUNT, 0, 0, 1'b0);
    write_bit_count(1);
    send_request(FN_GET, 0, 0, 1'b0);
    send_request(FN_GET, 1, 0, 1'b0);
    send_request(FN_COUNT, 0, 0, 1'b0);
    // Bits above the size keep their value when the size grows again.
    write_bit_count(2047);
    send_request(FN_COUNT, 0, 0, 1'b0);
    send_request(FN_FIRST, 1000, 0, 1'b0);
  endtask

  task automatic random_requests(int n, int size_hi);
    int off;
    int len;
    int room;
    logic [2:0] fn;
    write_bit_count($urandom_range(1, size_hi));
    for (int i = 0; i < n; i++) begin
      fn = ($urandom_range(99) < 4) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      off = ($urandom_range(99) < 88 && shadow_size > 0) ?
            $urandom_range(0, shadow_size - 1) : $urandom_range(0, 1023);
      room = (shadow_size > off) ? shadow_size - off : 1;
      case ($urandom_range(9))
        0: len = $urandom_range(0, 2047);
        1: len = 0;
        default: len = $urandom_range(1, (fn == FN_REGION && room > 8) ? 8 : room);
      endcase
      send_request(fn, off, len, 1'($urandom_range(1)));
    end
  endtask

  task automatic test_random_mixed();
    for (int phase = 0; phase < 14; phase++)
      random_requests(50, (phase == 6) ? 2047 : 96);
  endtask

  task automatic test_no_idle_stretch();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_requests(60, 64);
    send_idle_pct = 37;
    recv_idle_pct = 37;
  endtask

  task automatic test_output_hold_off();
    write_bit_count(40);
    hold_off_request = 400;
    for (int i = 0; i < 12; i++)
      send_request(3'($urandom_range(0, 4)), $urandom_range(0, 39), $urandom_range(1, 4),
                   1'($urandom_range(1)));
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    shadow_bits = '0;
    shadow_size = BITS_MAX;
    error_count = 0;
    cycle_count = 0;
    hold_off_request = 0;
    send_idle_pct = 37;
    recv_idle_pct = 37;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_full_size();
    test_size_extremes();
    test_output_hold_off();
    test_no_idle_stretch();
    test_random_mixed();

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("bitmap_allocator_engine regression: pass");
    end else begin
      $display("bitmap_allocator_engine regression: fail");
    end
    $finish;
  end

endmodule

// ===== bitmap_allocator_engine.f =====
design/bae_pkg.sv
design/bae_mem.sv
design/bae_seq.sv
design/bitmap_allocator_engine.sv
sim/bitmap_allocator_engine_test.sv
